### hdl/kmpe_pkg.sv
// Package with the item types, register codes and sizes of the key matrix press encoder.
package kmpe_pkg;

  localparam int NUM_ROWS = 8;
  localparam int NUM_COLS = 8;
  localparam int NUM_KEYS = NUM_ROWS * NUM_COLS;
  localparam int POS_W = 6;
  localparam int CODE_W = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEFT_SHIFT  = 2'd0,
    REG_RIGHT_SHIFT = 2'd1,
    REG_CONTROL     = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  localparam logic [POS_W-1:0] LEFT_SHIFT_RESET  = 6'd24;
  localparam logic [POS_W-1:0] RIGHT_SHIFT_RESET = 6'd46;
  localparam logic [POS_W-1:0] CONTROL_RESET     = 6'd16;

  typedef struct packed {
    logic [7:0] row0_columns;
    logic [7:0] row1_columns;
    logic [7:0] row2_columns;
    logic [7:0] row3_columns;
    logic [7:0] row4_columns;
    logic [7:0] row5_columns;
    logic [7:0] row6_columns;
    logic [7:0] row7_columns;
  } scan_t;

  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic              shift_held;
    logic              control_held;
    logic              last_of_scan;
  } result_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] press;
    logic                shift_held;
    logic                control_held;
  } job_t;

endpackage

### hdl/kmpe_front.sv
// Front end: holds the previous scan and the key positions, and turns each scan into a press job.
module kmpe_front
  import kmpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  scan_t                  in_item,
  input  logic                   queue_full,
  output logic                   job_push,
  output job_t                   job,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]       cfg_data
);

  logic [NUM_KEYS-1:0] previous_scan;
  logic [POS_W-1:0]    left_shift_position;
  logic [POS_W-1:0]    right_shift_position;
  logic [POS_W-1:0]    control_position;
  logic [NUM_KEYS-1:0] current_scan;
  logic                accept;

  assign current_scan = {in_item.row7_columns, in_item.row6_columns, in_item.row5_columns,
                         in_item.row4_columns, in_item.row3_columns, in_item.row2_columns,
                         in_item.row1_columns, in_item.row0_columns};
  assign accept   = push && !queue_full;
  assign job_push = accept;

  always_comb begin
    job.press        = previous_scan & ~current_scan;
    job.shift_held   = !current_scan[left_shift_position] ||
                       !current_scan[right_shift_position];
    job.control_held = !current_scan[control_position];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_scan <= '0;
    end else if (accept) begin
      previous_scan <= current_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_shift_position  <= LEFT_SHIFT_RESET;
      right_shift_position <= RIGHT_SHIFT_RESET;
      control_position     <= CONTROL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEFT_SHIFT:  left_shift_position  <= cfg_data;
        REG_RIGHT_SHIFT: right_shift_position <= cfg_data;
        REG_CONTROL:     control_position     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hdl/kmpe_queue.sv
// Short job queue in flip-flops between the front end and the back end.
module kmpe_queue
  import kmpe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_data,
  output logic full,
  input  logic rd,
  output job_t rd_data,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hdl/kmpe_back.sv
// Back end: walks the press mask of one job bit by bit and emits one key code per press.
module kmpe_back
  import kmpe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    job_empty,
  input  job_t    job,
  output logic    job_pop,
  output logic    empty,
  input  logic    pop,
  output result_t out_item
);

  localparam int IDX_W = $clog2(NUM_KEYS);

  logic                busy;
  logic [NUM_KEYS-1:0] mask;
  logic [IDX_W-1:0]    idx;
  logic                shift_held;
  logic                control_held;
  logic                out_valid;
  logic                slot_free;
  logic                step;
  logic                rest_clear;

  assign slot_free  = !out_valid || pop;
  assign step       = busy && (!mask[0] || slot_free);
  assign rest_clear = (mask[NUM_KEYS-1:1] == '0);
  assign job_pop    = !busy && !job_empty;
  assign empty      = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (job_pop) begin
      busy <= (job.press != '0);
    end else if (step && rest_clear) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      mask         <= job.press;
      idx          <= '0;
      shift_held   <= job.shift_held;
      control_held <= job.control_held;
    end else if (step) begin
      mask <= mask >> 1;
      idx  <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && mask[0]) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && mask[0]) begin
      out_item.key_code     <= CODE_W'(idx) + CODE_W'(1);
      out_item.shift_held   <= shift_held;
      out_item.control_held <= control_held;
      out_item.last_of_scan <= rest_clear;
    end
  end

endmodule

### hdl/key_matrix_press_encoder.sv
// Top level of the key matrix press encoder: front end, job queue and back end.
//
//   Channel   Handshake           Payload
//   input     push / full         in_item  (scan_t, eight rows of active-low columns)
//   result    empty / pop         out_item (result_t, key code, flags, last mark)
//   config    cfg_write           cfg_index selects the register, cfg_data holds the position
//
// A scan is taken whenever the job queue has room; its press mask and flags are then
// walked by the back end one matrix bit per cycle, ending early after its last press. A
// press waits while the result register is still held. Reset clears the previous scan to
// all zeros, restores the key positions and empties the queue and the result register.
module key_matrix_press_encoder
  import kmpe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  scan_t                  in_item,
  output logic                   empty,
  input  logic                   pop,
  output result_t                out_item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]       cfg_data
);

  logic job_push;
  job_t job_in;
  job_t job_out;
  logic job_pop;
  logic job_empty;

  kmpe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_item    (in_item),
    .queue_full (full),
    .job_push   (job_push),
    .job        (job_in),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  kmpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_data (job_in),
    .full    (full),
    .rd      (job_pop),
    .rd_data (job_out),
    .empty   (job_empty)
  );

  kmpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

### tb/sv/tb_key_matrix_press_encoder.sv
// Self-checking testbench for the key matrix press encoder, with its own press predictor.
`timescale 1ns / 1ps

module tb_key_matrix_press_encoder;
  import kmpe_pkg::*;

  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  scan_t                  in_item = '1;
  logic                   empty;
  logic                   pop = 1'b0;
  result_t                out_item;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [POS_W-1:0]       cfg_data = '0;

  key_matrix_press_encoder dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_item(in_item),
    .empty(empty),
    .pop(pop),
    .out_item(out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: the last scan seen and the configured key positions.
  logic [NUM_COLS-1:0] previous_rows [NUM_ROWS] = '{default: '0};
  logic [POS_W-1:0]    left_shift_pos = LEFT_SHIFT_RESET;
  logic [POS_W-1:0]    right_shift_pos = RIGHT_SHIFT_RESET;
  logic [POS_W-1:0]    control_pos = CONTROL_RESET;

  scan_t   pending_scans[$];
  result_t expected_codes[$];
  scan_t   last_scan = '1;
  int      mismatch_count = 0;
  int      sender_gap_max = 0;
  int      receiver_stall_max = 0;
  int      send_gap = 0;
  int      recv_stall = 0;
  bit      long_hold_req = 1'b0;
  int      long_hold_left = 0;
  int      cycle_count = 0;

  // Row 0 occupies the top byte of the packed scan.
  function automatic int key_index(logic [POS_W-1:0] pos);
    return (NUM_ROWS - 1 - int'(pos[5:3])) * NUM_COLS + int'(pos[2:0]);
  endfunction

  function automatic void encode_presses(scan_t s);
    logic [POS_W-1:0] pos;
    logic             cur_bit;
    logic             shift;
    logic             ctrl;
    bit               held;
    result_t          code;
    held = 1'b0;
    code = '0;
    shift = !s[key_index(left_shift_pos)] || !s[key_index(right_shift_pos)];
    ctrl = !s[key_index(control_pos)];
    for (int p = 0; p < NUM_KEYS; p++) begin
      pos = POS_W'(p);
      cur_bit = s[key_index(pos)];
      if (previous_rows[pos[5:3]][pos[2:0]] && !cur_bit) begin
        if (held) begin
          expected_codes.push_back(code);
        end
        code.key_code = CODE_W'(p + 1);
        code.shift_held = shift;
        code.control_held = ctrl;
        code.last_of_scan = 1'b0;
        held = 1'b1;
      end
      previous_rows[pos[5:3]][pos[2:0]] = cur_bit;
    end
    if (held) begin
      code.last_of_scan = 1'b1;
      expected_codes.push_back(code);
    end
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (expected_codes.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("unexpected result: code %0d shift %0b ctrl %0b last %0b",
                 got.key_code, got.shift_held, got.control_held, got.last_of_scan);
      end
    end else begin
      want = expected_codes.pop_front();
      if (got.key_code !== want.key_code || got.shift_held !== want.shift_held ||
          got.control_held !== want.control_held ||
          got.last_of_scan !== want.last_of_scan) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("mismatch: expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                   want.key_code, want.shift_held, want.control_held, want.last_of_scan,
                   got.key_code, got.shift_held, got.control_held, got.last_of_scan);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    logic next_push;
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      next_push = push;
      if (push && !full) begin
        encode_presses(in_item);
        next_push = 1'b0;
        send_gap = $urandom_range(0, sender_gap_max);
      end
      if (!next_push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_scans.size() > 0) begin
          in_item <= pending_scans.pop_front();
          next_push = 1'b1;
        end
      end
      push <= next_push;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      recv_stall = 0;
    end else begin
      if (pop && !empty) begin
        check_result(out_item);
        recv_stall = $urandom_range(0, receiver_stall_max);
      end
      if (long_hold_left > 0) begin
        pop <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_left <= LONG_HOLD_CYCLES;
      long_hold_req = 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_key_matrix_press_encoder: FAIL");
      $finish;
    end
  end

  function automatic scan_t pressed(scan_t base, logic [POS_W-1:0] pos);
    scan_t s;
    s = base;
    s[key_index(pos)] = 1'b0;
    return s;
  endfunction

  function automatic void queue_scan(scan_t s);
    pending_scans.push_back(s);
    last_scan = s;
  endfunction

  // Mostly a few keys changing from the last scan, with some noise and whole-matrix scans.
  function automatic scan_t next_scan();
    scan_t s;
    int    kind;
    int    pick;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      s = scan_t'({$urandom, $urandom});
    end else if (kind < 15) begin
      s = '1;
    end else if (kind < 18) begin
      s = '0;
    end else begin
      s = last_scan;
      repeat ($urandom_range(1, 4)) s[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          s[key_index(left_shift_pos)] = 1'($urandom_range(0, 1));
        end else if (pick == 1) begin
          s[key_index(right_shift_pos)] = 1'($urandom_range(0, 1));
        end else begin
          s[key_index(control_pos)] = 1'($urandom_range(0, 1));
        end
      end
    end
    return s;
  endfunction

  task automatic settle();
    while (pending_scans.size() != 0 || push || expected_codes.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_position(cfg_reg_t idx, logic [POS_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_LEFT_SHIFT: left_shift_pos = value;
      REG_RIGHT_SHIFT: right_shift_pos = value;
      REG_CONTROL: control_pos = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed scans with the reset key positions.
    sender_gap_max = 7;
    receiver_stall_max = 3;
    queue_scan({8'h00, {7{8'hFF}}});
    queue_scan('1);
    queue_scan('1);
    queue_scan('0);
    queue_scan('0);
    queue_scan('1);
    queue_scan(pressed('1, 6'd0));
    queue_scan(pressed('1, 6'd63));
    queue_scan(pressed('1, LEFT_SHIFT_RESET));
    queue_scan(pressed(pressed('1, LEFT_SHIFT_RESET), RIGHT_SHIFT_RESET));
    queue_scan(pressed('1, RIGHT_SHIFT_RESET));
    queue_scan(pressed(pressed('1, CONTROL_RESET), 6'd5));
    queue_scan({8{8'h55}});
    queue_scan({8{8'hAA}});
    queue_scan({8{8'h55}});
    queue_scan('1);
    queue_scan({8'hFE, {6{8'hFF}}, 8'h7F});
    settle();

    write_position(REG_LEFT_SHIFT, 6'd0);
    write_position(REG_RIGHT_SHIFT, 6'd63);
    write_position(REG_CONTROL, 6'd0);
    write_position(REG_UNUSED, 6'h3F);
    sender_gap_max = 7;
    receiver_stall_max = 0;
    repeat (55) queue_scan(next_scan());
    settle();

    // The receiver holds off while full scans keep arriving back to back.
    write_position(REG_LEFT_SHIFT, 6'd63);
    write_position(REG_RIGHT_SHIFT, 6'd0);
    write_position(REG_CONTROL, 6'd63);
    sender_gap_max = 0;
    receiver_stall_max = 0;
    long_hold_req = 1'b1;
    repeat (3) begin
      queue_scan('0);
      queue_scan('1);
    end
    repeat (55) queue_scan(next_scan());
    settle();

    write_position(REG_LEFT_SHIFT, POS_W'($urandom_range(0, NUM_KEYS - 1)));
    write_position(REG_RIGHT_SHIFT, POS_W'($urandom_range(0, NUM_KEYS - 1)));
    write_position(REG_CONTROL, POS_W'($urandom_range(0, NUM_KEYS - 1)));
    sender_gap_max = 7;
    receiver_stall_max = 7;
    repeat (37) queue_scan(next_scan());
    settle();

    if (mismatch_count == 0) begin
      $display("tb_key_matrix_press_encoder: PASS");
    end else begin
      $display("tb_key_matrix_press_encoder: FAIL");
    end
    $finish;
  end

endmodule
